[rtl/totp_pkg.sv]
// ----------------------------------------------------------------------------
// totp_pkg
// shared types, constants and sha-1 round helpers for the one-time code block
// ----------------------------------------------------------------------------
`default_nettype none

package totp_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [0:4]  digest_t;
  typedef word_t [0:15] block_t;

  // working variables, message window (w[0] is the current word), chaining value
  typedef struct packed {
    word_t [0:4]  s;
    word_t [0:15] w;
    word_t [0:4]  h;
  } sha_st_t;

  localparam int unsigned ROUNDS = 80;
  localparam int unsigned SB_W_DEF = 1;
  localparam int unsigned WINDOW_SECONDS_DEF = 30;

  localparam digest_t SHA1_IV = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                 32'h10325476, 32'hC3D2E1F0};
  localparam logic [7:0] IPAD = 8'h36;
  localparam logic [7:0] OPAD = 8'h5C;

  // apb register indexes (paddr[4:3])
  localparam logic [1:0] REG_KEY0 = 2'd0;
  localparam logic [1:0] REG_KEY1 = 2'd1;
  localparam logic [1:0] REG_KEY2 = 2'd2;

  localparam int unsigned ALPHA_SIZE = 26;
  localparam int unsigned CODE_CHARS = 5;
  localparam logic [0:25][7:0] ALPHABET = "23456789BCDFGHJKMNPQRTVWXY";

  typedef logic [0:CODE_CHARS-1][6:0] code_t;

  function automatic logic [6:0] alpha_char(logic [4:0] idx);
    logic [6:0] c;
    if (idx < 5'(ALPHA_SIZE)) c = ALPHABET[idx][6:0];
    else c = ALPHABET[0][6:0];
    return c;
  endfunction

  function automatic sha_st_t sha_round(sha_st_t x, int unsigned t);
    word_t   f, k, tmp, nw;
    sha_st_t y;
    if (t < 20) begin
      f = (x.s[1] & x.s[2]) | (~x.s[1] & x.s[3]);
      k = 32'h5A827999;
    end else if (t < 40) begin
      f = x.s[1] ^ x.s[2] ^ x.s[3];
      k = 32'h6ED9EBA1;
    end else if (t < 60) begin
      f = (x.s[1] & x.s[2]) | (x.s[1] & x.s[3]) | (x.s[2] & x.s[3]);
      k = 32'h8F1BBCDC;
    end else begin
      f = x.s[1] ^ x.s[2] ^ x.s[3];
      k = 32'hCA62C1D6;
    end
    tmp = {x.s[0][26:0], x.s[0][31:27]} + f + x.s[4] + k + x.w[0];
    nw  = x.w[13] ^ x.w[8] ^ x.w[2] ^ x.w[0];
    y.h = x.h;
    y.s = {tmp, x.s[0], {x.s[1][1:0], x.s[1][31:2]}, x.s[2], x.s[3]};
    y.w = {x.w[1:15], {nw[30:0], nw[31]}};
    return y;
  endfunction

  function automatic sha_st_t sha_final(sha_st_t x);
    sha_st_t y;
    y = x;
    for (int i = 0; i < 5; i++) y.s[i] = x.h[i] + x.s[i];
    return y;
  endfunction

endpackage

`default_nettype wire

[rtl/totp_sha1_blk.sv]
// ----------------------------------------------------------------------------
// totp_sha1_blk
// one sha-1 compression, one round per stage plus a final add stage
// ----------------------------------------------------------------------------
`default_nettype none

module totp_sha1_blk #(
  parameter int unsigned SB_W = totp_pkg::SB_W_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  totp_pkg::digest_t h_i,
  input  totp_pkg::block_t  blk_i,
  input  logic [SB_W-1:0]   sb_i,
  output totp_pkg::digest_t h_o,
  output logic [SB_W-1:0]   sb_o
);
  import totp_pkg::*;

  sha_st_t         st_q [ROUNDS+1];
  logic [SB_W-1:0] sb_q [ROUNDS+1];
  sha_st_t         init_st;

  always_comb begin
    init_st.s = h_i;
    init_st.w = blk_i;
    init_st.h = h_i;
  end

  for (genvar t = 0; t <= ROUNDS; t++) begin : g_stg
    sha_st_t         st_d;
    logic [SB_W-1:0] sb_d;

    if (t == 0) begin : g_first
      assign st_d = sha_round(init_st, 0);
      assign sb_d = sb_i;
    end else if (t < ROUNDS) begin : g_mid
      assign st_d = sha_round(st_q[t-1], t);
      assign sb_d = sb_q[t-1];
    end else begin : g_fin
      // feed-forward add of the chaining value
      assign st_d = sha_final(st_q[t-1]);
      assign sb_d = sb_q[t-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) st_q[t] <= st_d;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sb_q[t] <= '0;
      end else if (en_i) begin
        sb_q[t] <= sb_d;
      end
    end
  end

  assign h_o  = st_q[ROUNDS].s;
  assign sb_o = sb_q[ROUNDS];

endmodule

`default_nettype wire

[rtl/totp_hmac_sha1_alpha_code_top.sv]
// throughput: one beat per cycle; every stage is one register slice and the
//   whole pipe advances together, held only while the result beat is not taken
// reset: valid bits and key registers clear asynchronously, the key reads as zero
// ----------------------------------------------------------------------------
// totp_hmac_sha1_alpha_code_top
// time window counter, hmac-sha1 under the configured key, dynamic truncation
// and five base-26 letters
// ----------------------------------------------------------------------------
`default_nettype none

module totp_hmac_sha1_alpha_code_top #(
  parameter int unsigned WINDOW_SECONDS = totp_pkg::WINDOW_SECONDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // input beat
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [62:0] epoch_sec_i,
  // result beat
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  char_0_o,
  output logic [6:0]  char_1_o,
  output logic [6:0]  char_2_o,
  output logic [6:0]  char_3_o,
  output logic [6:0]  char_4_o
);
  import totp_pkg::*;

  // divider by the window length: 8 quotient bits per stage
  localparam int unsigned DIV_BITS = 8;
  localparam int unsigned DIV_STG  = 64 / DIV_BITS;
  localparam int unsigned RW       = $clog2(WINDOW_SECONDS + 1);
  // base-26 digit stages: 32-bit dividend, 8 bits per stage
  localparam int unsigned DG_SUB   = 32 / DIV_BITS;
  localparam int unsigned DG_STG   = CODE_CHARS * DG_SUB;

  // ---------------- configuration ----------------
  logic [63:0] key0_q, key1_q;
  logic [31:0] key2_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q <= '0;
      key1_q <= '0;
      key2_q <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        REG_KEY0: key0_q <= pwdata;
        REG_KEY1: key1_q <= pwdata;
        REG_KEY2: key2_q <= pwdata[31:0];
        default: ;  // no register there
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_KEY0: prdata = key0_q;
      REG_KEY1: prdata = key1_q;
      REG_KEY2: prdata = {32'b0, key2_q};
      default:  prdata = '0;
    endcase
  end

  // padded key blocks; user keeps key stable while items in flight, unenforced
  logic [159:0] key_bits;
  block_t       ikey_blk, okey_blk;

  assign key_bits = {key0_q, key1_q, key2_q};
  assign ikey_blk = block_t'({key_bits ^ {20{IPAD}}, {44{IPAD}}});
  assign okey_blk = block_t'({key_bits ^ {20{OPAD}}, {44{OPAD}}});

  // ---------------- global pipe advance ----------------
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // ---------------- stage group 1: time / window ----------------
  // restoring division, dividend shifts out the top while quotient bits shift in
  logic [63:0]   dv_x_q [DIV_STG];
  logic [RW-1:0] dv_r_q [DIV_STG];
  logic          dv_v_q [DIV_STG];

  for (genvar s = 0; s < DIV_STG; s++) begin : g_div
    logic [63:0]   x_src, x_d;
    logic [RW-1:0] r_src, r_d;
    logic          v_src;
    logic [RW:0]   tmp;

    if (s == 0) begin : g_in
      assign x_src = {1'b0, epoch_sec_i};
      assign r_src = '0;
      assign v_src = in_valid_i;
    end else begin : g_chain
      assign x_src = dv_x_q[s-1];
      assign r_src = dv_r_q[s-1];
      assign v_src = dv_v_q[s-1];
    end

    always_comb begin
      x_d = x_src;
      r_d = r_src;
      tmp = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
        tmp = {r_d, x_d[63]};
        x_d = {x_d[62:0], 1'b0};
        if (tmp >= (RW+1)'(WINDOW_SECONDS)) begin
          tmp    = tmp - (RW+1)'(WINDOW_SECONDS);
          x_d[0] = 1'b1;
        end
        r_d = tmp[RW-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_x_q[s] <= x_d;
        dv_r_q[s] <= r_d;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[s] <= 1'b0;
      end else if (en) begin
        dv_v_q[s] <= v_src;
      end
    end
  end

  // ---------------- stage group 2: inner hash ----------------
  // first block: key xor ipad, sideband carries valid and the window counter
  digest_t     h1;
  logic [64:0] sb1;

  totp_sha1_blk #(.SB_W(65)) u_inner_key (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .h_i    (SHA1_IV),
    .blk_i  (ikey_blk),
    .sb_i   ({dv_v_q[DIV_STG-1], dv_x_q[DIV_STG-1]}),
    .h_o    (h1),
    .sb_o   (sb1)
  );

  // second block: counter, padding, length of 72 bytes
  block_t  imsg_blk;
  digest_t inner;
  logic    sb2;

  assign imsg_blk = block_t'({sb1[63:0], 8'h80, 424'b0, 16'd576});

  totp_sha1_blk #(.SB_W(1)) u_inner_msg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .h_i    (h1),
    .blk_i  (imsg_blk),
    .sb_i   (sb1[64]),
    .h_o    (inner),
    .sb_o   (sb2)
  );

  // ---------------- stage group 3: outer hash ----------------
  digest_t      h3;
  logic [160:0] sb3;

  totp_sha1_blk #(.SB_W(161)) u_outer_key (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .h_i    (SHA1_IV),
    .blk_i  (okey_blk),
    .sb_i   ({sb2, inner}),
    .h_o    (h3),
    .sb_o   (sb3)
  );

  // inner digest, padding, length of 84 bytes
  block_t  omsg_blk;
  digest_t mac;
  logic    sb4;

  assign omsg_blk = block_t'({sb3[159:0], 8'h80, 328'b0, 16'd672});

  totp_sha1_blk #(.SB_W(1)) u_outer_msg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .h_i    (h3),
    .blk_i  (omsg_blk),
    .sb_i   (sb3[160]),
    .h_o    (mac),
    .sb_o   (sb4)
  );

  // ---------------- dynamic truncation ----------------
  // offset from the low nibble of the last byte, pick four bytes, drop the top bit
  logic [159:0] mac_bits, mac_sh;
  logic [31:0]  tr_val_q;
  logic         tr_v_q;

  assign mac_bits = mac;
  assign mac_sh   = mac_bits << {mac_bits[3:0], 3'b000};

  always_ff @(posedge clk_i) begin
    if (en) tr_val_q <= {1'b0, mac_sh[158:128]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tr_v_q <= 1'b0;
    end else if (en) begin
      tr_v_q <= sb4;
    end
  end

  // ---------------- base-26 digits ----------------
  // each digit takes four division stages; the last one maps the remainder
  // to a letter and the quotient feeds the next digit
  logic [31:0] dg_x_q [DG_STG];
  logic [4:0]  dg_r_q [DG_STG];
  code_t       dg_c_q [DG_STG];
  logic        dg_v_q [DG_STG];

  for (genvar k = 0; k < DG_STG; k++) begin : g_dig
    logic [31:0] x_src, x_d;
    logic [4:0]  r_src, r_d;
    code_t       c_src, c_d;
    logic        v_src;
    logic [5:0]  tmp;

    if (k == 0) begin : g_in
      assign x_src = tr_val_q;
      assign c_src = '0;
      assign v_src = tr_v_q;
    end else begin : g_chain
      assign x_src = dg_x_q[k-1];
      assign c_src = dg_c_q[k-1];
      assign v_src = dg_v_q[k-1];
    end

    if (k % DG_SUB == 0) begin : g_start
      assign r_src = '0;
    end else begin : g_cont
      assign r_src = dg_r_q[k-1];
    end

    always_comb begin
      x_d = x_src;
      r_d = r_src;
      c_d = c_src;
      tmp = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
        tmp = {r_d, x_d[31]};
        x_d = {x_d[30:0], 1'b0};
        if (tmp >= 6'(ALPHA_SIZE)) begin
          tmp    = tmp - 6'(ALPHA_SIZE);
          x_d[0] = 1'b1;
        end
        r_d = tmp[4:0];
      end
      if (k % DG_SUB == DG_SUB - 1) c_d[k / DG_SUB] = alpha_char(r_d);
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dg_x_q[k] <= x_d;
        dg_r_q[k] <= r_d;
        dg_c_q[k] <= c_d;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dg_v_q[k] <= 1'b0;
      end else if (en) begin
        dg_v_q[k] <= v_src;
      end
    end
  end

  // last digit stage is the output register
  assign out_valid_o = dg_v_q[DG_STG-1];
  assign char_0_o    = dg_c_q[DG_STG-1][0];
  assign char_1_o    = dg_c_q[DG_STG-1][1];
  assign char_2_o    = dg_c_q[DG_STG-1][2];
  assign char_3_o    = dg_c_q[DG_STG-1][3];
  assign char_4_o    = dg_c_q[DG_STG-1][4];

endmodule

`default_nettype wire

[dv/tb_totp_hmac_sha1_alpha_code_top.sv]
// ----------------------------------------------------------------------------
// tb_totp_hmac_sha1_alpha_code_top
// self-checking bench for the hmac-sha1 time-window code block: it stalls both
// sides at random, and a class keeps its own key copy and hash predictor and
// compares every result beat in order against the predicted five letters
// ----------------------------------------------------------------------------
`default_nettype none

class totp_code_scoreboard;
  localparam logic [0:25][7:0] CODE_LETTERS = "23456789BCDFGHJKMNPQRTVWXY";

  bit [63:0]           key_hi;
  bit [63:0]           key_mid;
  bit [31:0]           key_lo;
  totp_pkg::code_t     code_queue[$];
  int                  mismatches;
  int                  checked;
  int                  noted;

  function void write_key(logic [1:0] idx, bit [63:0] value);
    case (idx)
      totp_pkg::REG_KEY0: key_hi = value;
      totp_pkg::REG_KEY1: key_mid = value;
      totp_pkg::REG_KEY2: key_lo = value[31:0];
      default: ;
    endcase
  endfunction

  // value a register read should return
  function bit [63:0] read_key(logic [1:0] idx);
    bit [63:0] v;
    case (idx)
      totp_pkg::REG_KEY0: v = key_hi;
      totp_pkg::REG_KEY1: v = key_mid;
      totp_pkg::REG_KEY2: v = {32'b0, key_lo};
      default: v = '0;
    endcase
    return v;
  endfunction

  function bit [31:0] rotl(bit [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function void compress(ref bit [31:0] h[5], input bit [7:0] blk[64]);
    bit [31:0] w[80];
    bit [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 80; i++)
      w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = rotl(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rotl(b, 30); b = a; a = t;
    end
    h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
  endfunction

  // sha-1 of (key padded to one block, xor pad) followed by a short tail
  function void padded_hash(bit [7:0] key[20], bit [7:0] pad, bit [7:0] tail[20],
                            int n, output bit [7:0] dig[20]);
    bit [7:0]  blk[64];
    bit [31:0] h[5];
    bit [15:0] bits;
    bits = 16'((64 + n) * 8);
    h = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};
    for (int i = 0; i < 64; i++) blk[i] = (i < 20) ? key[i] ^ pad : pad;
    compress(h, blk);
    for (int i = 0; i < 64; i++) blk[i] = (i < n) ? tail[i] : 8'h00;
    blk[n] = 8'h80;
    blk[62] = bits[15:8];
    blk[63] = bits[7:0];
    compress(h, blk);
    for (int i = 0; i < 20; i++) dig[i] = h[i/4][31 - 8*(i%4) -: 8];
  endfunction

  function totp_pkg::code_t code_for_time(bit [62:0] epoch_sec);
    bit [7:0]        key[20], msg[20], inner[20], mac[20];
    bit [63:0]       window;
    bit [31:0]       value;
    int              off;
    totp_pkg::code_t code;
    window = {1'b0, epoch_sec} / 64'd30;
    for (int i = 0; i < 20; i++) msg[i] = 8'h00;
    for (int i = 0; i < 8; i++) begin
      key[i]     = key_hi[63 - 8*i -: 8];
      key[8 + i] = key_mid[63 - 8*i -: 8];
      msg[i]     = window[63 - 8*i -: 8];
    end
    for (int i = 0; i < 4; i++) key[16 + i] = key_lo[31 - 8*i -: 8];
    padded_hash(key, totp_pkg::IPAD, msg, 8, inner);
    padded_hash(key, totp_pkg::OPAD, inner, 20, mac);
    off = mac[19][3:0];
    value = {mac[off] & 8'h7F, mac[off+1], mac[off+2], mac[off+3]};
    for (int i = 0; i < 5; i++) begin
      code[i] = CODE_LETTERS[value % 26][6:0];
      value = value / 26;
    end
    return code;
  endfunction

  function void note_time(bit [62:0] epoch_sec);
    code_queue.push_back(code_for_time(epoch_sec));
    noted++;
  endfunction

  function void check_code(totp_pkg::code_t got);
    totp_pkg::code_t want;
    if (code_queue.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("result beat with nothing expected: %h", got);
      return;
    end
    want = code_queue.pop_front();
    checked++;
    for (int i = 0; i < 5; i++)
      if (want[i] !== got[i]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("char_%0d mismatch on result %0d: expected %h got %h",
                   i, checked, want[i], got[i]);
      end
  endfunction

  function int pending();
    return code_queue.size();
  endfunction
endclass

module tb_totp_hmac_sha1_alpha_code_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 400;   // a little over the depth of the pipe
  localparam logic [1:0] REG_NONE = 2'd3;

  logic        clk_i, rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [63:0] pwdata, prdata;
  logic        in_valid_i, in_ready_o;
  logic [62:0] epoch_sec_i;
  logic        out_valid_o, out_ready_i;
  logic [6:0]  char_0_o, char_1_o, char_2_o, char_3_o, char_4_o;

  totp_code_scoreboard code_sb;
  int  cycles;
  int  send_idle_pct, recv_idle_pct;   // percent of cycles each side idles
  int  hold_request;                   // long receiver hold-off, in cycles
  int  hold_left;
  int  key_writes;

  totp_hmac_sha1_alpha_code_top dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // global watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // input and result beats are both taken at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      code_sb.check_code({char_0_o, char_1_o, char_2_o, char_3_o, char_4_o});
  end

  // receiver: random stalls, plus a long hold-off when asked
  initial begin
    out_ready_i = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i = 1'b0;
      end else begin
        out_ready_i = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // apb write: setup cycle then access cycle, register taken on the access edge
  task automatic reg_write(logic [1:0] idx, logic [63:0] value);
    @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 3'b000}; pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    code_sb.write_key(idx, value);
    key_writes++;
    // read back through the still-addressed register
    if (!pready || prdata !== code_sb.read_key(idx)) begin
      code_sb.mismatches++;
      if (code_sb.mismatches <= 10)
        $display("register %0d read back: expected %h got %h",
                 idx, code_sb.read_key(idx), prdata);
    end
  endtask

  // one input beat: valid stays up across back-to-back beats
  task automatic send_time(logic [62:0] t);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    epoch_sec_i = t;
    do @(posedge clk_i); while (!in_ready_o);
    code_sb.note_time(t);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // key writes only happen once the pipe is empty
  task automatic drain();
    stop_sending();
    while (code_sb.pending() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [62:0] random_time();
    logic [62:0] t;
    case ($urandom_range(3))
      0: t = 63'({$urandom, $urandom});
      1: t = 63'($urandom_range(0, 2000));
      2: t = 63'({$urandom, $urandom} % 64'd300000000) * 63'd30
             + ($urandom_range(1) ? 63'd29 : 63'd0);
      default: t = ~63'($urandom_range(0, 100));
    endcase
    return t;
  endfunction

  initial begin
    logic [62:0] edge_times[$];
    code_sb = new();
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid_i = 1'b0; epoch_sec_i = '0;
    send_idle_pct = 0; recv_idle_pct = 0; hold_request = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // all-zero key straight out of reset, window edges and extreme times
    edge_times = '{63'd0, 63'd29, 63'd30, 63'd59, 63'd60, 63'h7FFF_FFFF_FFFF_FFFF,
                   63'h7FFF_FFFF_FFFF_FFFE, 63'h4000_0000_0000_0000,
                   63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA};
    foreach (edge_times[i]) send_time(edge_times[i]);
    drain();

    // well-known ascii test key; junk in the upper half of the short register
    // and a write to an unmapped index must both be ignored
    reg_write(totp_pkg::REG_KEY0, 64'h3132_3334_3536_3738);
    reg_write(totp_pkg::REG_KEY1, 64'h3930_3132_3334_3536);
    reg_write(totp_pkg::REG_KEY2, 64'hDEAD_BEEF_3738_3930);
    reg_write(REG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
    edge_times = '{63'd59, 63'd1111111109, 63'd1111111111, 63'd1234567890,
                   63'd2000000000, 63'd20000000000};
    foreach (edge_times[i]) send_time(edge_times[i]);
    drain();

    // all-ones key
    reg_write(totp_pkg::REG_KEY0, '1);
    reg_write(totp_pkg::REG_KEY1, '1);
    reg_write(totp_pkg::REG_KEY2, '1);
    edge_times = '{63'd0, 63'h7FFF_FFFF_FFFF_FFFF, 63'd89, 63'd90};
    foreach (edge_times[i]) send_time(edge_times[i]);
    drain();

    // random phases: fresh key each time, three stall profiles
    for (int phase = 0; phase < 6; phase++) begin
      reg_write(totp_pkg::REG_KEY0, {$urandom, $urandom});
      reg_write(totp_pkg::REG_KEY1, {$urandom, $urandom});
      reg_write(totp_pkg::REG_KEY2, {$urandom, $urandom});
      case (phase / 2)
        0: begin send_idle_pct = 32; recv_idle_pct = 68; end
        1: begin send_idle_pct = 68; recv_idle_pct = 32; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      // long receiver hold-off with more beats than the pipe holds, so it
      // fills completely and the input stalls
      if (phase == 4) hold_request = 1200;
      for (int n = 0; n < ((phase == 4) ? 400 : 116); n++) send_time(random_time());
      drain();
    end

    $display("checked %0d codes from %0d times over %0d key writes",
             code_sb.checked, code_sb.noted, key_writes);
    $display("keys: zero, ascii, all-ones and six random; stalls both ways and a full pipe");
    if (code_sb.mismatches == 0 && code_sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

`default_nettype wire
